// ===== hdl/bldc_pkg.sv =====
// Shared constants, widths and commutation tables for the sensorless six-step commutator.
package bldc_pkg;

  // Payload field widths.
  localparam int EMF_W     = 10;
  localparam int TICK_W    = 32;
  localparam int GATE_W    = 6;
  localparam int STEP_W    = 3;

  // Datapath widths.
  localparam int ADC_BITS  = 10;
  localparam int TICK_BITS = 32;
  localparam int DELTA_W   = ADC_BITS + 1;
  localparam int SUM_W     = ADC_BITS + 2;
  localparam int PERIOD_W  = 12;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(4000);
  localparam logic [STEP_W-1:0]   STEP_FIRST   = STEP_W'(1);
  localparam logic [STEP_W-1:0]   STEP_LAST    = STEP_W'(6);

  // floor(sum / 3) as (sum * DIV3_MUL) >> DIV3_SHIFT. The reciprocal is rounded up;
  // its error times the largest sum stays below 2**DIV3_SHIFT, so the result is exact.
  localparam int DIV3_SHIFT = ADC_BITS + 4;
  localparam int DIV3_MUL   = (2 ** DIV3_SHIFT + 2) / 3;
  localparam int DIV3_PROD_W = SUM_W + DIV3_SHIFT;

  // floor(pot * 98 / 100) = floor(pot * 49 / 50) as (pot * PER_MUL) >> PER_SHIFT,
  // exact by the same argument.
  localparam int PER_SHIFT  = ADC_BITS + 6;
  localparam int PER_MUL    = (49 * (2 ** PER_SHIFT) + 49) / 50;
  localparam int PER_PROD_W = ADC_BITS + PER_SHIFT;

  typedef enum logic [1:0] {
    PH_X = 2'd0,
    PH_Y = 2'd1,
    PH_Z = 2'd2
  } phase_t;

  // Gate drive pattern per step: bits 5..0 = XH, XL, YH, YL, ZH, ZL.
  function automatic logic [GATE_W-1:0] gate_for_step(input logic [STEP_W-1:0] step);
    logic [GATE_W-1:0] g;
    case (step)
      3'd1: g = 6'b000110;   // Y low, Z high
      3'd2: g = 6'b100100;   // X high, Y low
      3'd3: g = 6'b100001;   // X high, Z low
      3'd4: g = 6'b001001;   // Y high, Z low
      3'd5: g = 6'b011000;   // X low, Y high
      3'd6: g = 6'b010010;   // X low, Z high
      default: g = 6'b000110;
    endcase
    return g;
  endfunction

  // The phase left floating in each step, whose back-EMF is watched.
  function automatic phase_t float_for_step(input logic [STEP_W-1:0] step);
    phase_t p;
    case (step)
      3'd1, 3'd4: p = PH_X;
      3'd2, 3'd5: p = PH_Z;
      3'd3, 3'd6: p = PH_Y;
      default:    p = PH_X;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/bldc_if.sv =====
// Valid/ready channel interfaces for sample rounds and commutation results.
interface bldc_in_if;
  import bldc_pkg::*;
  logic              valid;
  logic              ready;
  logic [EMF_W-1:0]  emf_phase_x;
  logic [EMF_W-1:0]  emf_phase_y;
  logic [EMF_W-1:0]  emf_phase_z;
  logic [EMF_W-1:0]  speed_pot;
  logic [TICK_W-1:0] tick_now;

  modport source (output valid, emf_phase_x, emf_phase_y, emf_phase_z, speed_pot, tick_now,
                  input ready);
  modport sink (input valid, emf_phase_x, emf_phase_y, emf_phase_z, speed_pot, tick_now,
                output ready);
endinterface

interface bldc_out_if;
  import bldc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [GATE_W-1:0]         gate_bits;
  logic [STEP_W-1:0]         step_now;
  logic signed [DELTA_W-1:0] float_delta;
  logic                      fired;

  modport source (output valid, gate_bits, step_now, float_delta, fired, input ready);
  modport sink (input valid, gate_bits, step_now, float_delta, fired, output ready);
endinterface

// ===== hdl/bldc_sensorless_six_step.sv =====
// Six-step sensorless BLDC commutator: top level with input register and result register.
//
// Each input item is one sampling round (three back-EMF samples, the speed
// potentiometer and the microsecond tick) and produces exactly one result item.
// The block takes one item per clock cycle while the result channel is not stalled.
// Each result passes the input register and then the state registers. The cycle
// in which an item is accepted forms the three-phase average and the next
// commutation period, both by constant-reciprocal multiplications, and
// registers them with the samples. From the input register, the second stage
// compares the elapsed tick time with the current period, advances the deadline
// on expiry, picks the gate pattern and the floating phase of the current step,
// checks the back-EMF difference for a sign change and updates the commutator
// state. The state registers themselves drive the result channel, and they
// change only when the previous result has been taken, so a stalled output holds
// its item while one more item waits in the input register. Gate bits and the
// floating delta hold their values between expiries; the fired flag marks the
// items on which the period ran out. After reset all gates are off, the step is
// 1 and the period is 4000 ticks.
module bldc_sensorless_six_step (
  input logic         clk,
  input logic         rst,
  bldc_in_if.sink     in_ch,
  bldc_out_if.source  out_ch
);
  import bldc_pkg::*;

  // Input register stage.
  logic                s1_valid;
  logic [ADC_BITS-1:0] s1_ex;
  logic [ADC_BITS-1:0] s1_ey;
  logic [ADC_BITS-1:0] s1_ez;
  logic [ADC_BITS-1:0] s1_avg;
  logic [PERIOD_W-1:0] s1_period;
  logic [TICK_BITS-1:0] s1_tick;

  // Commutator state; gate, step, delta and fired also form the result item.
  logic                      out_valid;
  logic [STEP_W-1:0]         step_reg;
  logic signed [DELTA_W-1:0] last_delta;
  logic [PERIOD_W-1:0]       period_reg;
  logic [TICK_BITS-1:0]      deadline_base;
  logic [GATE_W-1:0]         gate_reg;
  logic signed [DELTA_W-1:0] delta_reg;
  logic                      fired_reg;

  // First-stage arithmetic on the incoming samples.
  logic [SUM_W-1:0]       emf_sum;
  logic [DIV3_PROD_W-1:0] avg_prod;
  logic [PER_PROD_W-1:0]  per_prod;

  assign emf_sum  = SUM_W'(in_ch.emf_phase_x[ADC_BITS-1:0])
                  + SUM_W'(in_ch.emf_phase_y[ADC_BITS-1:0])
                  + SUM_W'(in_ch.emf_phase_z[ADC_BITS-1:0]);
  assign avg_prod = DIV3_PROD_W'(emf_sum) * DIV3_PROD_W'(DIV3_MUL);
  assign per_prod = PER_PROD_W'(in_ch.speed_pot[ADC_BITS-1:0]) * PER_PROD_W'(PER_MUL);

  // Flow control: the state stage loads a held item when the result slot is empty or being taken.
  logic out_load;
  logic in_take;

  assign out_load    = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || out_load;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Second-stage commutation logic.
  logic [TICK_BITS-1:0]      elapsed;
  logic                      fire;
  logic [STEP_W-1:0]         step_eff;
  logic [STEP_W-1:0]         step_adv;
  phase_t                    float_sel;
  logic [ADC_BITS-1:0]       phase_val;
  logic signed [DELTA_W-1:0] delta_new;
  logic                      delta_pos;
  logic                      last_pos;
  logic                      sign_change;

  assign elapsed = s1_tick - deadline_base;
  assign fire    = elapsed >= TICK_BITS'(period_reg);

  // A step outside 1..6 cannot arise, but it would be handled as step 1.
  assign step_eff = (step_reg >= STEP_FIRST && step_reg <= STEP_LAST) ? step_reg : STEP_FIRST;
  assign step_adv = (step_eff == STEP_LAST) ? STEP_FIRST : step_eff + STEP_W'(1);

  assign float_sel = float_for_step(step_eff);

  always_comb begin
    case (float_sel)
      PH_X:    phase_val = s1_ex;
      PH_Y:    phase_val = s1_ey;
      PH_Z:    phase_val = s1_ez;
      default: phase_val = s1_ex;
    endcase
  end

  assign delta_new   = $signed({1'b0, phase_val}) - $signed({1'b0, s1_avg});
  assign delta_pos   = !delta_new[DELTA_W-1] && (delta_new != '0);
  assign last_pos    = !last_delta[DELTA_W-1] && (last_delta != '0);
  assign sign_change = last_pos ? !delta_pos : delta_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ex     <= in_ch.emf_phase_x[ADC_BITS-1:0];
      s1_ey     <= in_ch.emf_phase_y[ADC_BITS-1:0];
      s1_ez     <= in_ch.emf_phase_z[ADC_BITS-1:0];
      s1_avg    <= avg_prod[DIV3_SHIFT +: ADC_BITS];
      s1_period <= PERIOD_W'(per_prod[PER_SHIFT +: ADC_BITS]);
      s1_tick   <= in_ch.tick_now[TICK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      step_reg      <= STEP_FIRST;
      last_delta    <= -DELTA_W'(1);
      period_reg    <= PERIOD_RESET;
      deadline_base <= '0;
      gate_reg      <= '0;
      delta_reg     <= '0;
      fired_reg     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        fired_reg  <= fire;
        period_reg <= s1_period;
        if (fire) begin
          deadline_base <= deadline_base + TICK_BITS'(period_reg);
          gate_reg      <= gate_for_step(step_eff);
          delta_reg     <= delta_new;
          if (sign_change) begin
            last_delta <= delta_new;
            step_reg   <= step_adv;
          end else begin
            step_reg <= step_eff;
          end
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.gate_bits   = gate_reg;
  assign out_ch.step_now    = step_reg;
  assign out_ch.float_delta = delta_reg;
  assign out_ch.fired       = fired_reg;

endmodule

// ===== hdl/bldc_check.sv =====
// Port-level assertions for the six-step commutator and the bind that attaches them.
module bldc_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bldc_pkg::GATE_W-1:0]        gate_bits,
  input logic [bldc_pkg::STEP_W-1:0]        step_now,
  input logic signed [bldc_pkg::DELTA_W-1:0] float_delta,
  input logic                               fired
);
  import bldc_pkg::*;

  // Last result item taken from the output.
  logic                      prev_seen;
  logic [GATE_W-1:0]         prev_gate;
  logic [STEP_W-1:0]         prev_step;
  logic signed [DELTA_W-1:0] prev_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_gate  <= gate_bits;
      prev_step  <= step_now;
      prev_delta <= float_delta;
    end
  end

  // A stalled result item keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gate_bits) && $stable(step_now)
                                && $stable(float_delta) && $stable(fired))
    else $error("result item changed while stalled");

  // With no result pending, the block must take input.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // The step stays within one through six.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_now >= STEP_FIRST && step_now <= STEP_LAST)
    else $error("commutation step out of range");

  // On expiry exactly one high-side and one low-side switch of different phases conduct.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> $countones(gate_bits) == 2)
    else $error("bad gate pattern on expiry");

  // Without expiry, the commutator state shown is the one of the previous item.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired && prev_seen |-> gate_bits == prev_gate && step_now == prev_step
                                         && float_delta == prev_delta)
    else $error("state changed without expiry");

endmodule

bind bldc_sensorless_six_step bldc_check u_bldc_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .gate_bits   (out_ch.gate_bits),
  .step_now    (out_ch.step_now),
  .float_delta (out_ch.float_delta),
  .fired       (out_ch.fired)
);
